// ===== sv/picture_reorder_min_poc_buffer_defines.svh =====
// ---------------------------------------------------------------------------
// Reorder buffer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PICTURE_REORDER_MIN_POC_BUFFER_DEFINES_SVH
`define PICTURE_REORDER_MIN_POC_BUFFER_DEFINES_SVH

// Same-cycle implication.
`define PRMP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PRMP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/prmp_pkg.sv =====
// ---------------------------------------------------------------------------
// Reorder buffer package
// Sizes, payload types, cell commands and the entry ordering function.
// ---------------------------------------------------------------------------
`default_nettype none

package prmp_pkg;

  localparam int MAX_DEPTH = 16;
  localparam int TAG_BITS  = 8;
  localparam int POC_W     = 32;
  localparam int CFG_W     = 5;
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int SLOT_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef struct packed {
    logic [TAG_BITS-1:0] picture_tag;
    logic [POC_W-1:0]    order_count;
    logic                is_idr;
    logic                is_final;
  } in_item_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] out_tag;
    logic [POC_W-1:0]    out_order_count;
    logic                last_of_run;
  } out_item_t;

  // One held picture; slot is its position in arrival/slot order.
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [POC_W-1:0]    order_count;
    logic [SLOT_W-1:0]   slot;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REPLACE,
    OP_DRAIN
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } chain_ctrl_t;

  // Lower order count first; equal counts go to the lower slot.
  function automatic logic entry_less(entry_t a, entry_t b);
    logic lt_cnt;
    logic eq_cnt;
    lt_cnt = $signed(a.order_count) < $signed(b.order_count);
    eq_cnt = a.order_count == b.order_count;
    return lt_cnt || (eq_cnt && (a.slot < b.slot));
  endfunction

endpackage

`default_nettype wire

// ===== sv/prmp_cell.sv =====
// ---------------------------------------------------------------------------
// Reorder buffer cell
// Holds one picture of the sorted row and takes data from either neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module prmp_cell (
  input  wire                          clk,
  input  prmp_pkg::chain_ctrl_t        ctrl,
  input  wire [prmp_pkg::SLOT_W-1:0]   rel_slot,
  input  wire                          head_i,
  input  wire                          occupied_i,
  input  prmp_pkg::entry_t             up_entry_i,
  input  wire                          up_lt_i,
  input  prmp_pkg::entry_t             dn_entry_i,
  input  wire                          dn_lt_i,
  output prmp_pkg::entry_t             entry_o,
  output logic                         lt_o
);

  prmp_pkg::entry_t entry_r;
  prmp_pkg::entry_t entry_nxt;

  assign entry_o = entry_r;
  assign lt_o    = occupied_i && prmp_pkg::entry_less(entry_r, ctrl.new_entry);

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      prmp_pkg::OP_INSERT: begin
        // Cells below the insertion point keep, the point takes the new
        // picture, the rest move up by one.
        if (lt_o) begin
          entry_nxt = entry_r;
        end else if (head_i || dn_lt_i) begin
          entry_nxt = ctrl.new_entry;
        end else begin
          entry_nxt = dn_entry_i;
        end
      end
      prmp_pkg::OP_REPLACE: begin
        // The head leaves; the cells below the new picture move down.
        if (up_lt_i) begin
          entry_nxt = up_entry_i;
        end else if (head_i || lt_o) begin
          entry_nxt = ctrl.new_entry;
        end else begin
          entry_nxt = entry_r;
        end
      end
      prmp_pkg::OP_DRAIN: begin
        entry_nxt = up_entry_i;
        if (up_entry_i.slot > rel_slot) begin
          entry_nxt.slot = up_entry_i.slot - prmp_pkg::SLOT_W'(1);
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/prmp_chain.sv =====
// ---------------------------------------------------------------------------
// Reorder buffer cell row
// A row of cells kept sorted by order count and slot, with the fill count.
// ---------------------------------------------------------------------------
`default_nettype none

`include "picture_reorder_min_poc_buffer_defines.svh"

module prmp_chain (
  input  wire                          clk,
  input  wire                          rst_n,
  input  prmp_pkg::chain_ctrl_t        ctrl,
  output prmp_pkg::entry_t             head_o,
  output logic [prmp_pkg::CNT_W-1:0]   count_o
);

  localparam int N = prmp_pkg::MAX_DEPTH;

  logic [prmp_pkg::CNT_W-1:0] count_r;
  logic [prmp_pkg::CNT_W-1:0] count_nxt;

  prmp_pkg::entry_t cell_e   [N];
  logic             cell_lt  [N];
  prmp_pkg::entry_t up_e     [N];
  logic             up_lt    [N];
  prmp_pkg::entry_t dn_e     [N];
  logic             dn_lt    [N];
  logic             occupied [N];

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign occupied[g] = prmp_pkg::CNT_W'(g) < count_r;

    if (g == N - 1) begin : g_top
      assign up_e[g]  = '0;
      assign up_lt[g] = 1'b0;
    end else begin : g_mid_up
      assign up_e[g]  = cell_e[g+1];
      assign up_lt[g] = cell_lt[g+1];
    end

    if (g == 0) begin : g_bottom
      assign dn_e[g]  = '0;
      assign dn_lt[g] = 1'b0;
    end else begin : g_mid_dn
      assign dn_e[g]  = cell_e[g-1];
      assign dn_lt[g] = cell_lt[g-1];
    end

    prmp_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .rel_slot   (cell_e[0].slot),
      .head_i     (g == 0),
      .occupied_i (occupied[g]),
      .up_entry_i (up_e[g]),
      .up_lt_i    (up_lt[g]),
      .dn_entry_i (dn_e[g]),
      .dn_lt_i    (dn_lt[g]),
      .entry_o    (cell_e[g]),
      .lt_o       (cell_lt[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    case (ctrl.op)
      prmp_pkg::OP_INSERT: count_nxt = count_r + prmp_pkg::CNT_W'(1);
      prmp_pkg::OP_DRAIN:  count_nxt = count_r - prmp_pkg::CNT_W'(1);
      default:             count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_o  = cell_e[0];
  assign count_o = count_r;

  `PRMP_ASSERT_IMP(a_count_bound, 1'b1, count_r <= prmp_pkg::CNT_W'(N), "fill count past depth")
  `PRMP_ASSERT_IMP(a_drain_nonempty, ctrl.op == prmp_pkg::OP_DRAIN, count_r != '0, "drain on empty row")
  `PRMP_ASSERT_IMP(a_head_is_min, occupied[1], !prmp_pkg::entry_less(cell_e[1], cell_e[0]), "head is not the minimum")

endmodule

`default_nettype wire

// ===== sv/picture_reorder_min_poc_buffer.sv =====
// Busy stays high while an item passes the IDR drain, the main decision, the final
// drain and the flush; the drains run only on an IDR or final mark.
// The last result is on the ports in the first cycle with busy low.
// A new item is taken only while idle, so each item is through before the next; the
// drain of one picture per cycle through the head cell sets the pace. Results cannot
// be stalled. Synchronous active-low reset empties the buffer and zeroes the depth.
// ---------------------------------------------------------------------------
// Picture reorder buffer, minimum order count bumping
// Holds decoded pictures in a row of cells sorted by order count and releases
// them in display order.
// ---------------------------------------------------------------------------
`default_nettype none

`include "picture_reorder_min_poc_buffer_defines.svh"

module picture_reorder_min_poc_buffer (
  input  wire                          clk,
  input  wire                          rst_n,
  // Input item channel.
  input  wire                          start,
  output logic                         busy,
  input  prmp_pkg::in_item_t           in_item,
  // Result channel: one strobe per released picture.
  output logic                         out_valid,
  output prmp_pkg::out_item_t          out_item,
  // Depth register write channel.
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [prmp_pkg::CFG_W-1:0]    cfg_data
);

  // The sequencer walks an item through up to four phases: the IDR drain,
  // the main decision, the final drain and a flush of the pending result.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_MAIN,
    S_POST,
    S_FLUSH
  } state_t;

  state_t                          state_r, state_nxt;
  prmp_pkg::in_item_t              item_r;
  logic [prmp_pkg::CFG_W-1:0]      depth_r;

  // Each release first lands in a pending register, so the last result of an
  // item can be marked when the sequencer knows nothing else follows.
  logic                            pend_valid_r, pend_valid_nxt;
  logic [prmp_pkg::TAG_BITS-1:0]   pend_tag_r, pend_tag_nxt;
  logic [prmp_pkg::POC_W-1:0]      pend_cnt_r, pend_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  prmp_pkg::out_item_t             out_item_r, out_item_nxt;

  prmp_pkg::chain_ctrl_t           ctrl;
  prmp_pkg::entry_t                head;
  logic [prmp_pkg::CNT_W-1:0]      count;
  logic [prmp_pkg::CNT_W-1:0]      depth_sat;
  logic                            emit;
  logic                            flush;
  logic [prmp_pkg::TAG_BITS-1:0]   emit_tag;
  logic [prmp_pkg::POC_W-1:0]      emit_cnt;
  logic                            accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = state_r != S_IDLE;
  assign cfg_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Depths beyond the row length behave as the full row.
  assign depth_sat = (32'(depth_r) > 32'(prmp_pkg::MAX_DEPTH))
                   ? prmp_pkg::CNT_W'(prmp_pkg::MAX_DEPTH)
                   : prmp_pkg::CNT_W'(depth_r);

  prmp_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .head_o  (head),
    .count_o (count)
  );

  always_comb begin
    state_nxt = state_r;
    ctrl.op   = prmp_pkg::OP_HOLD;
    ctrl.new_entry.tag         = item_r.picture_tag;
    ctrl.new_entry.order_count = item_r.order_count;
    // A picture that fills an open place takes the next free slot.
    ctrl.new_entry.slot        = count[prmp_pkg::SLOT_W-1:0];
    emit     = 1'b0;
    flush    = 1'b0;
    emit_tag = head.tag;
    emit_cnt = head.order_count;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = in_item.is_idr ? S_PRE : S_MAIN;
        end
      end
      S_PRE, S_POST: begin
        // Release the head once per cycle until the row is empty.
        if (count != '0) begin
          ctrl.op = prmp_pkg::OP_DRAIN;
          emit    = 1'b1;
        end
        if (count <= prmp_pkg::CNT_W'(1)) begin
          state_nxt = (state_r == S_PRE) ? S_MAIN : S_FLUSH;
        end
      end
      S_MAIN: begin
        state_nxt = item_r.is_final ? S_POST : S_FLUSH;
        if (depth_sat == '0) begin
          emit     = 1'b1;
          emit_tag = item_r.picture_tag;
          emit_cnt = item_r.order_count;
        end else if (count < depth_sat) begin
          ctrl.op = prmp_pkg::OP_INSERT;
        end else if ($signed(item_r.order_count) < $signed(head.order_count)) begin
          // The new picture is older than everything held: it goes out at once.
          emit     = 1'b1;
          emit_tag = item_r.picture_tag;
          emit_cnt = item_r.order_count;
        end else begin
          // The held minimum goes out and the new picture inherits its slot.
          emit                = 1'b1;
          ctrl.op             = prmp_pkg::OP_REPLACE;
          ctrl.new_entry.slot = head.slot;
        end
      end
      S_FLUSH: begin
        flush     = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt                = pend_valid_r && (emit || flush);
    out_item_nxt.out_tag         = pend_tag_r;
    out_item_nxt.out_order_count = pend_cnt_r;
    out_item_nxt.last_of_run     = flush;

    pend_valid_nxt = emit ? 1'b1 : (flush ? 1'b0 : pend_valid_r);
    pend_tag_nxt   = emit ? emit_tag : pend_tag_r;
    pend_cnt_nxt   = emit ? emit_cnt : pend_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      depth_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        depth_r <= cfg_data;
      end
    end
    if (accept) begin
      item_r <= in_item;
    end
    pend_tag_r <= pend_tag_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  `PRMP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `PRMP_ASSERT_IMP(a_idle_no_pending, state_r == S_IDLE, !pend_valid_r, "pending result left at idle")
  `PRMP_ASSERT_IMP(a_flush_marks_last, out_valid_r && out_item_r.last_of_run, state_r == S_IDLE, "last result outside flush")

endmodule

`default_nettype wire
